@@ design/mwa_pkg.sv @@
package mwa_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 16;

endpackage

@@ design/mwa_in_if.sv @@
interface mwa_in_if import mwa_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

@@ design/mwa_out_if.sv @@
interface mwa_out_if import mwa_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] plain_mean;
    logic [SAMPLE_BITS-1:0] weighted_mean;

    modport source (output valid, output plain_mean, output weighted_mean, input ready);
    modport sink   (input valid, input plain_mean, input weighted_mean, output ready);

endinterface

@@ design/mwa_sample_cell.sv @@
module mwa_sample_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    logic [SAMPLE_BITS-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_en) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

@@ design/mwa_div_cell.sv @@
module mwa_div_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int P_DIV       = 5,
    parameter int W_DIV       = 15,
    parameter int PR_W        = 19,
    parameter int WR_W        = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [PR_W-1:0]        i_psum,
    input  logic [WR_W-1:0]        i_wsum,
    output logic                   o_vld,
    output logic [SAMPLE_BITS-1:0] o_pq,
    output logic [SAMPLE_BITS-1:0] o_wq
);

    // A numerator below 2**PR_W times the rounded-up reciprocal, shifted right by
    // PR_W + clog2(divisor), gives the exact floored quotient.
    localparam int P_SH = PR_W + $clog2(P_DIV);
    localparam int W_SH = WR_W + $clog2(W_DIV);
    localparam logic [PR_W:0] P_MUL =
        (PR_W+1)'(((64'd1 << P_SH) + 64'(P_DIV) - 64'd1) / 64'(P_DIV));
    localparam logic [WR_W:0] W_MUL =
        (WR_W+1)'(((64'd1 << W_SH) + 64'(W_DIV) - 64'd1) / 64'(W_DIV));

    logic                   r_vld;
    logic [SAMPLE_BITS-1:0] r_pq;
    logic [SAMPLE_BITS-1:0] r_wq;
    logic [2*PR_W:0]        p_prod;
    logic [2*WR_W:0]        w_prod;
    logic [SAMPLE_BITS-1:0] n_pq;
    logic [SAMPLE_BITS-1:0] n_wq;

    assign p_prod = (2*PR_W+1)'(i_psum) * (2*PR_W+1)'(P_MUL);
    assign w_prod = (2*WR_W+1)'(i_wsum) * (2*WR_W+1)'(W_MUL);
    assign n_pq   = p_prod[P_SH +: SAMPLE_BITS];
    assign n_wq   = w_prod[W_SH +: SAMPLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pq <= n_pq;
            r_wq <= n_wq;
        end
    end

    assign o_vld = r_vld;
    assign o_pq  = r_pq;
    assign o_wq  = r_wq;

endmodule

@@ design/moving_and_weighted_average.sv @@
// Plain and linearly weighted moving average over the last WINDOW samples. Each input
// transaction yields one output transaction carrying the floored plain mean and the floored
// weighted mean (oldest weight 1, newest weight WINDOW); the window starts out as zeros.
// The block takes one transaction per clock while the output is not stalled. Each accepted
// sample first updates the registered running sums, which a registered divide stage then
// divides by their constant divisors through reciprocal multiplication. When the output is
// stalled, the whole pipeline and the input hold.
module moving_and_weighted_average import mwa_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mwa_in_if.sink    i_in,
    mwa_out_if.source o_out
);

    localparam int WSUM = WINDOW * (WINDOW + 1) / 2;
    localparam int PR_W = SAMPLE_BITS + $clog2(WINDOW + 1);
    localparam int WR_W = SAMPLE_BITS + $clog2(WSUM + 1);

    localparam logic [PR_W-1:0] P_OFF   = PR_W'(WINDOW) << (SAMPLE_BITS - 1);
    localparam logic [WR_W-1:0] P_OFF_W = WR_W'(WINDOW) << (SAMPLE_BITS - 1);
    localparam logic [WR_W-1:0] W_OFF   = WR_W'(WSUM) << (SAMPLE_BITS - 1);

    logic                   en;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] smp_chain [WINDOW+1];

    logic                   r_v0;
    logic [PR_W-1:0]        r_pacc;
    logic [WR_W-1:0]        r_wacc;
    logic [PR_W-1:0]        n_pacc;
    logic [WR_W-1:0]        n_wacc;

    logic                   dv_vld;
    logic [SAMPLE_BITS-1:0] dv_pq;
    logic [SAMPLE_BITS-1:0] dv_wq;

    assign en         = !dv_vld || o_out.ready;
    assign accept     = i_in.valid && en;
    assign i_in.ready = en;

    assign smp_chain[0] = i_in.sample;

    for (genvar k = 0; k < WINDOW; k++) begin : g_smp
        mwa_sample_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (accept),
            .i_sample (smp_chain[k]),
            .o_sample (smp_chain[k+1])
        );
    end

    // The sums are kept with an offset so that the dividers see non-negative numerators.
    always_comb begin
        n_pacc = r_pacc - PR_W'(signed'(smp_chain[WINDOW])) + PR_W'(signed'(i_in.sample));
        n_wacc = r_wacc - WR_W'(r_pacc) + P_OFF_W
                 + WR_W'(WINDOW) * WR_W'(signed'(i_in.sample));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pacc <= P_OFF;
            r_wacc <= W_OFF;
            r_v0   <= 1'b0;
        end else begin
            if (accept) begin
                r_pacc <= n_pacc;
                r_wacc <= n_wacc;
            end
            if (en) begin
                r_v0 <= accept;
            end
        end
    end

    mwa_div_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .P_DIV       (WINDOW),
        .W_DIV       (WSUM),
        .PR_W        (PR_W),
        .WR_W        (WR_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v0),
        .i_psum  (r_pacc),
        .i_wsum  (r_wacc),
        .o_vld   (dv_vld),
        .o_pq    (dv_pq),
        .o_wq    (dv_wq)
    );

    // Removing the offset from the quotient flips its top bit.
    assign o_out.valid         = dv_vld;
    assign o_out.plain_mean    = dv_pq ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign o_out.weighted_mean = dv_wq ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endmodule

@@ verif/moving_and_weighted_average_tb.sv @@
module moving_and_weighted_average_tb;
    import mwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN        = WINDOW_DEF;
    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int WEIGHT_SUM = WIN * (WIN + 1) / 2;
    localparam int LATENCY    = 2;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [SB-1:0] plain;
        logic [SB-1:0] weighted;
    } mean_pair_t;

    logic i_clk;
    logic i_rst_n;

    mwa_in_if  #(.SAMPLE_BITS(SB)) sample_in ();
    mwa_out_if #(.SAMPLE_BITS(SB)) mean_out ();

    moving_and_weighted_average #(
        .WINDOW      (WIN),
        .SAMPLE_BITS (SB)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_in.sink),
        .o_out   (mean_out.source)
    );

    logic [SB-1:0] sample_q[$];
    mean_pair_t    mean_expect_q[$];
    longint        window_ring[WIN];
    int            write_pos;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            mismatches;
    int            cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    task automatic push_and_predict_means(logic [SB-1:0] sample);
        longint     plain_sum;
        longint     weighted_sum;
        longint     quot;
        mean_pair_t pair;
        plain_sum    = 0;
        weighted_sum = 0;
        window_ring[write_pos] = longint'($signed(sample));
        write_pos = (write_pos + 1) % WIN;
        for (int j = 0; j < WIN; j++) begin
            plain_sum    += window_ring[j];
            weighted_sum += longint'(j + 1) * window_ring[(write_pos + j) % WIN];
        end
        quot = floor_div(plain_sum, WIN);
        pair.plain = quot[SB-1:0];
        quot = floor_div(weighted_sum, WEIGHT_SUM);
        pair.weighted = quot[SB-1:0];
        mean_expect_q.push_back(pair);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_in.valid <= 1'b0;
        end else begin
            if (sample_in.valid && sample_in.ready) begin
                push_and_predict_means(sample_in.sample);
            end
            if (!sample_in.valid || sample_in.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    sample_in.valid  <= 1'b1;
                    sample_in.sample <= sample_q.pop_front();
                end else begin
                    sample_in.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        mean_pair_t want;
        if (!i_rst_n) begin
            mean_out.ready <= 1'b0;
        end else begin
            if (mean_out.valid && mean_out.ready) begin
                if (mean_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected transaction: plain %0d weighted %0d",
                                 $signed(mean_out.plain_mean), $signed(mean_out.weighted_mean));
                    end
                end else begin
                    want = mean_expect_q.pop_front();
                    if (mean_out.plain_mean !== want.plain
                            || mean_out.weighted_mean !== want.weighted) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: plain exp %0d got %0d, weighted exp %0d got %0d",
                                     $signed(want.plain), $signed(mean_out.plain_mean),
                                     $signed(want.weighted), $signed(mean_out.weighted_mean));
                        end
                    end
                end
            end
            mean_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("moving_and_weighted_average_tb: errors");
            $finish;
        end
    end

    task automatic fill_random(int count);
        logic [SB-1:0] s;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: s = SB'($signed($urandom_range(16)) - 8);
                1: s = $urandom_range(1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
                default: s = SB'($urandom);
            endcase
            sample_q.push_back(s);
        end
    endtask

    task automatic drain_all();
        while (sample_q.size() != 0 || sample_in.valid || mean_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        sample_in.valid  = 1'b0;
        sample_in.sample = '0;
        mean_out.ready   = 1'b0;
        i_rst_n          = 1'b0;
        write_pos        = 0;
        mismatches       = 0;
        cycle_count      = 0;
        send_idle_pct    = 30;
        recv_stall_pct   = 30;
        for (int k = 0; k < WIN; k++) begin
            window_ring[k] = 0;
        end

        // The ring starts out as zeros, so the first transactions exercise the filling case
        // and floor rounding of small negative sums.
        sample_q.push_back(SB'(-1));
        sample_q.push_back(SB'(-2));
        sample_q.push_back(SB'(3));
        sample_q.push_back(SB'(0));
        sample_q.push_back(SB'(1));
        repeat (WIN) sample_q.push_back({1'b0, {(SB-1){1'b1}}});
        repeat (WIN) sample_q.push_back({1'b1, {(SB-1){1'b0}}});
        sample_q.push_back(16'h5555);
        sample_q.push_back(16'hAAAA);
        sample_q.push_back({1'b0, {(SB-1){1'b1}}});
        sample_q.push_back({1'b1, {(SB-1){1'b0}}});
        sample_q.push_back(SB'(-7));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain_all();

        send_idle_pct  = 8;
        recv_stall_pct = 66;
        fill_random(RANDOM_PER_PHASE);
        drain_all();

        send_idle_pct  = 66;
        recv_stall_pct = 8;
        fill_random(RANDOM_PER_PHASE);
        drain_all();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_random(RANDOM_PER_PHASE);
        drain_all();

        repeat (2 * LATENCY) @(posedge i_clk);

        if (mismatches == 0 && mean_expect_q.size() == 0) begin
            $display("moving_and_weighted_average_tb: clean");
        end else begin
            $display("moving_and_weighted_average_tb: errors");
        end
        $finish;
    end

endmodule
